FILE: sv/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on a clock, switched off while reset is low.
`define WB_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Concurrent assertion on a clock that also holds during reset.
`define WB_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/wblur_pkg.sv
// Package: payload types, field widths and constants of the weighted 3x3 blur.
package wblur_pkg;

    // Field widths
    localparam int SAMPLE_W   = 16;
    localparam int ROW_W      = 12;
    localparam int COL_W      = 10;
    localparam int FW_W       = 11;
    localparam int FH_W       = 13;
    localparam int WGT_W      = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    // Frame limits and register reset values
    localparam int MAX_WIDTH_DEF = 1024;
    localparam int MAX_HEIGHT    = 4096;
    localparam int FW_RST        = 1024;
    localparam int FH_RST        = 1024;
    localparam int NW_RST        = 2;
    localparam int CW_RST        = 84;

    // Saturation bounds of a sample
    localparam int SAMPLE_MAX = (1 << (SAMPLE_W - 1)) - 1;
    localparam int SAMPLE_MIN = -(1 << (SAMPLE_W - 1));

    // Datapath widths
    localparam int NSUM_W  = SAMPLE_W + 3;           // sum of eight samples
    localparam int NPROD_W = NSUM_W + WGT_W + 1;     // neighbor sum times weight
    localparam int CPROD_W = SAMPLE_W + WGT_W + 1;   // center times weight
    localparam int ACC_W   = NPROD_W + 1;
    localparam int MAG_W   = ACC_W - 1;

    // Divide by 100: floor(x * DIV_MAGIC / 2^DIV_SHIFT) is exact for x < 2^MAG_W
    localparam int          DIV_SHIFT   = 34;
    localparam int          DIV_MAGIC_W = 28;
    localparam int unsigned DIV_MAGIC   = 171798692;
    localparam int          PROD_W      = MAG_W + DIV_MAGIC_W;
    localparam int          QUO_W       = PROD_W - DIV_SHIFT;
    localparam int          QS_W        = QUO_W + 1;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH     = 2'd0,
        REG_FRAME_HEIGHT    = 2'd1,
        REG_NEIGHBOR_WEIGHT = 2'd2,
        REG_CENTER_WEIGHT   = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        sample_t sample;
        logic    frame_start;
    } in_item_t;

    typedef struct packed {
        sample_t           filtered;
        logic [ROW_W-1:0]  out_row;
        logic [COL_W-1:0]  out_col;
        logic              end_of_frame;
        logic              last_of_run;
    } out_item_t;

endpackage

FILE: sv/weighted_3x3_blur_clamped.sv
// Top level: streaming 3x3 weighted blur with replicate border and saturation.
//
// Usage:
//   s_valid/s_ready/s_item carry one sample per item in raster order; frame_start
//   puts the item at row 0, column 0. m_valid/m_ready/m_item carry the results,
//   each tagged with its row and column; last_of_run marks the final result of
//   an input item and end_of_frame the result for the bottom right position.
//   cfg_valid/cfg_ready/cfg_index/cfg_data write frame_width, frame_height,
//   neighbor_weight and center_weight; cfg_ready is always high. Write them only
//   while no item is in flight.
//   The input item that completes a neighborhood passes the stage 1 and stage 2
//   registers, C1..C4 and the output register before its result shows on m_item.
//   Throughput: one input item per cycle while each item causes at most one result
//   and m_ready stays high. Results leave the single issue stage one per cycle while
//   m_ready stays high, so an item with more results (last row or column) stalls input.
//   Two line memories (one read and one write port each) hold the previous rows.
//   Reset clears the registers to their defaults, the position to (0,0), the
//   window to zero and empties the pipeline; line memory contents are not
//   cleared. When the receiver stalls, the output register holds its item and
//   the pipeline keeps accepting input until its stages fill up.
module weighted_3x3_blur_clamped #(
    parameter int MAX_WIDTH = wblur_pkg::MAX_WIDTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  wblur_pkg::in_item_t                 s_item,
    output logic                                m_valid,
    input  logic                                m_ready,
    output wblur_pkg::out_item_t                m_item,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [wblur_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [wblur_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import wblur_pkg::*;

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

    typedef enum logic [1:0] {
        SLOT_CL = 2'd0,   // (r-1, c-1)
        SLOT_BL = 2'd1,   // (r,   c-1)
        SLOT_CR = 2'd2,   // (r-1, c)
        SLOT_BR = 2'd3    // (r,   c)
    } slot_t;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             eof;
        logic             last;
    } meta_t;

    // Configuration registers
    logic [FW_W-1:0]  cfg_width_reg;
    logic [FH_W-1:0]  cfg_height_reg;
    logic [WGT_W-1:0] cfg_nweight_reg;
    logic [WGT_W-1:0] cfg_cweight_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_width_reg   <= FW_W'(FW_RST);
            cfg_height_reg  <= FH_W'(FH_RST);
            cfg_nweight_reg <= WGT_W'(NW_RST);
            cfg_cweight_reg <= WGT_W'(CW_RST);
        end else if (cfg_valid) begin
            case (cfg_reg_t'(cfg_index))
                REG_FRAME_WIDTH:     cfg_width_reg   <= cfg_data[FW_W-1:0];
                REG_FRAME_HEIGHT:    cfg_height_reg  <= cfg_data[FH_W-1:0];
                REG_NEIGHBOR_WEIGHT: cfg_nweight_reg <= cfg_data[WGT_W-1:0];
                REG_CENTER_WEIGHT:   cfg_cweight_reg <= cfg_data[WGT_W-1:0];
                default: ;
            endcase
        end
    end

    // Last column and last row after clamping the frame size
    logic [CW-1:0]    w_last;
    logic [ROW_W-1:0] h_last;

    always_comb begin
        if (cfg_width_reg < FW_W'(2)) begin
            w_last = CW'(1);
        end else if (32'(cfg_width_reg) >= MAX_WIDTH) begin
            w_last = CW'(MAX_WIDTH - 1);
        end else begin
            w_last = CW'(cfg_width_reg - FW_W'(1));
        end
        if (cfg_height_reg < FH_W'(2)) begin
            h_last = ROW_W'(1);
        end else if (32'(cfg_height_reg) >= MAX_HEIGHT) begin
            h_last = ROW_W'(MAX_HEIGHT - 1);
        end else begin
            h_last = ROW_W'(cfg_height_reg - FH_W'(1));
        end
    end

    // Pipeline handshake signals
    logic s_fire;
    logic p1_valid_reg;
    logic p1_adv;
    logic p2_valid_reg;
    logic p2_free;
    logic c1_valid_reg, c2_valid_reg, c3_valid_reg, c4_valid_reg;
    logic c1_free, c2_free, c3_free, c4_free, c5_free;
    logic m_valid_reg;

    assign c5_free = !m_valid_reg || m_ready;
    assign c4_free = !c4_valid_reg || c5_free;
    assign c3_free = !c3_valid_reg || c4_free;
    assign c2_free = !c2_valid_reg || c3_free;
    assign c1_free = !c1_valid_reg || c2_free;

    assign p1_adv  = p1_valid_reg && p2_free;
    assign s_ready = !p1_valid_reg || p2_free;
    assign s_fire  = s_valid && s_ready;

    // Position of the incoming item
    logic [ROW_W-1:0] in_row_reg, in_row_next;
    logic [CW-1:0]    in_col_reg, in_col_next;
    logic [ROW_W-1:0] pos_row;
    logic [CW-1:0]    pos_col;
    logic             pos_last_row, pos_last_col;

    always_comb begin
        if (s_item.frame_start) begin
            pos_row = '0;
            pos_col = '0;
        end else begin
            pos_row = (in_row_reg > h_last) ? h_last : in_row_reg;
            pos_col = (in_col_reg > w_last) ? w_last : in_col_reg;
        end
        pos_last_row = (pos_row == h_last);
        pos_last_col = (pos_col == w_last);
    end

    always_comb begin
        in_row_next = in_row_reg;
        in_col_next = in_col_reg;
        if (s_fire) begin
            if (pos_last_col) begin
                in_col_next = '0;
                in_row_next = pos_last_row ? '0 : pos_row + ROW_W'(1);
            end else begin
                in_col_next = pos_col + CW'(1);
                in_row_next = pos_row;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_row_reg <= '0;
            in_col_reg <= '0;
        end else begin
            in_row_reg <= in_row_next;
            in_col_reg <= in_col_next;
        end
    end

    // Stage 1 registers: item after acceptance, line memory data arrives
    sample_t          p1_sample_reg;
    logic [ROW_W-1:0] p1_row_reg;
    logic [CW-1:0]    p1_col_reg;
    logic             p1_last_row_reg, p1_last_col_reg;
    logic             fwd_reg;
    sample_t          fwd_above_reg, fwd_cur_reg;
    sample_t          rd_above_reg, rd_cur_reg;
    sample_t          p1_a, p1_b;

    // Line memories: rows r-2 and r-1
    sample_t line_above_mem [MAX_WIDTH];
    sample_t line_cur_mem   [MAX_WIDTH];

    // The stage 1 item writes back in the same cycle a new item reads;
    // forward its values when both touch the same column
    assign p1_a = fwd_reg ? fwd_above_reg : rd_above_reg;
    assign p1_b = fwd_reg ? fwd_cur_reg   : rd_cur_reg;

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            rd_above_reg <= line_above_mem[pos_col];
        end
        if (p1_adv) begin
            line_above_mem[p1_col_reg] <= p1_b;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            rd_cur_reg <= line_cur_mem[pos_col];
        end
        if (p1_adv) begin
            line_cur_mem[p1_col_reg] <= p1_sample_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            fwd_reg      <= 1'b0;
        end else begin
            if (s_ready) begin
                p1_valid_reg <= s_valid;
            end
            if (s_fire) begin
                fwd_reg <= p1_adv && (p1_col_reg == pos_col);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            p1_sample_reg   <= s_item.sample;
            p1_row_reg      <= pos_row;
            p1_col_reg      <= pos_col;
            p1_last_row_reg <= pos_last_row;
            p1_last_col_reg <= pos_last_col;
            fwd_above_reg   <= p1_b;
            fwd_cur_reg     <= p1_sample_reg;
        end
    end

    // Results caused by the stage 1 item, in output order
    logic [3:0] p1_pend;
    logic       p1_has_row, p1_has_col;

    always_comb begin
        p1_has_row = (p1_row_reg != '0);
        p1_has_col = (p1_col_reg != '0);
        p1_pend    = '0;
        p1_pend[SLOT_CL] = p1_has_row && p1_has_col;
        p1_pend[SLOT_BL] = p1_has_row && p1_has_col && p1_last_row_reg;
        p1_pend[SLOT_CR] = p1_has_row && p1_last_col_reg;
        p1_pend[SLOT_BR] = p1_has_row && p1_last_col_reg && p1_last_row_reg;
    end

    // 3x3 window: row 0 = r-2, row 1 = r-1, row 2 = r; column 2 newest
    sample_t win_reg [3][3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    win_reg[i][j] <= '0;
                end
            end
        end else if (p1_adv) begin
            for (int i = 0; i < 3; i++) begin
                win_reg[i][0] <= win_reg[i][1];
                win_reg[i][1] <= win_reg[i][2];
            end
            win_reg[0][2] <= p1_a;
            win_reg[1][2] <= p1_b;
            win_reg[2][2] <= p1_sample_reg;
        end
    end

    // Stage 2: issue the pending results one per cycle while stage C1 is free
    logic [ROW_W-1:0] p2_row_reg;
    logic [CW-1:0]    p2_col_reg;
    logic             p2_top_reg, p2_left_reg;
    logic [3:0]       p2_pend_reg;
    slot_t            issue_slot;
    logic [3:0]       pend_after;
    logic             issue_req, issue_fire, issue_last;

    always_comb begin
        if (p2_pend_reg[SLOT_CL]) begin
            issue_slot = SLOT_CL;
        end else if (p2_pend_reg[SLOT_BL]) begin
            issue_slot = SLOT_BL;
        end else if (p2_pend_reg[SLOT_CR]) begin
            issue_slot = SLOT_CR;
        end else begin
            issue_slot = SLOT_BR;
        end
        pend_after = p2_pend_reg;
        pend_after[issue_slot] = 1'b0;
    end

    assign issue_req  = p2_valid_reg && (p2_pend_reg != '0);
    assign issue_fire = issue_req && c1_free;
    assign issue_last = (pend_after == '0);
    assign p2_free    = !p2_valid_reg || (p2_pend_reg == '0) || (c1_free && issue_last);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p2_valid_reg <= 1'b0;
            p2_pend_reg  <= '0;
        end else if (p2_free) begin
            p2_valid_reg <= p1_valid_reg;
            p2_pend_reg  <= p1_pend;
        end else if (issue_fire) begin
            p2_pend_reg  <= pend_after;
        end
    end

    always_ff @(posedge aclk) begin
        if (p1_adv) begin
            p2_row_reg  <= p1_row_reg;
            p2_col_reg  <= p1_col_reg;
            p2_top_reg  <= (p1_row_reg == ROW_W'(1));
            p2_left_reg <= (p1_col_reg == CW'(1));
        end
    end

    // Neighborhood of the issued position with the border replicated
    logic    is_bot, is_right, lclamp;
    sample_t row_u [3];
    sample_t row_c [3];
    sample_t row_d [3];
    sample_t n_ul, n_uc, n_ur, n_cl, n_cr, n_dl, n_dc, n_dr, n_ctr;
    logic signed [NSUM_W-1:0] nsum;
    meta_t   issue_meta;

    assign is_bot   = (issue_slot == SLOT_BL) || (issue_slot == SLOT_BR);
    assign is_right = (issue_slot == SLOT_CR) || (issue_slot == SLOT_BR);
    assign lclamp   = is_right || p2_left_reg;

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            row_u[j] = (is_bot || p2_top_reg) ? win_reg[1][j] : win_reg[0][j];
            row_c[j] = is_bot ? win_reg[2][j] : win_reg[1][j];
            row_d[j] = win_reg[2][j];
        end
        n_ul  = lclamp ? row_u[1] : row_u[0];
        n_uc  = is_right ? row_u[2] : row_u[1];
        n_ur  = row_u[2];
        n_cl  = lclamp ? row_c[1] : row_c[0];
        n_ctr = is_right ? row_c[2] : row_c[1];
        n_cr  = row_c[2];
        n_dl  = lclamp ? row_d[1] : row_d[0];
        n_dc  = is_right ? row_d[2] : row_d[1];
        n_dr  = row_d[2];
        nsum  = NSUM_W'(n_ul) + NSUM_W'(n_uc) + NSUM_W'(n_ur) + NSUM_W'(n_cl)
              + NSUM_W'(n_cr) + NSUM_W'(n_dl) + NSUM_W'(n_dc) + NSUM_W'(n_dr);
    end

    always_comb begin
        issue_meta.row  = is_bot ? p2_row_reg : p2_row_reg - ROW_W'(1);
        issue_meta.col  = is_right ? COL_W'(p2_col_reg) : COL_W'(p2_col_reg - CW'(1));
        issue_meta.eof  = (issue_slot == SLOT_BR);
        issue_meta.last = issue_last;
    end

    // Compute stages C1..C4 and the output register
    logic signed [NSUM_W-1:0]  c1_nsum_reg;
    sample_t                   c1_center_reg;
    meta_t                     c1_meta_reg, c2_meta_reg, c3_meta_reg, c4_meta_reg;
    logic signed [NPROD_W-1:0] c2_nprod_reg;
    logic signed [CPROD_W-1:0] c2_cprod_reg;
    logic [MAG_W-1:0]          c3_mag_reg;
    logic                      c3_neg_reg, c4_neg_reg;
    logic [PROD_W-1:0]         c4_prod_reg;
    out_item_t                 m_item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c1_valid_reg <= 1'b0;
            c2_valid_reg <= 1'b0;
            c3_valid_reg <= 1'b0;
            c4_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (c1_free) c1_valid_reg <= issue_req;
            if (c2_free) c2_valid_reg <= c1_valid_reg;
            if (c3_free) c3_valid_reg <= c2_valid_reg;
            if (c4_free) c4_valid_reg <= c3_valid_reg;
            if (c5_free) m_valid_reg  <= c4_valid_reg;
        end
    end

    // Weight products
    logic signed [NPROD_W-1:0] nprod;
    logic signed [CPROD_W-1:0] cprod;

    assign nprod = NPROD_W'(c1_nsum_reg) * NPROD_W'($signed({1'b0, cfg_nweight_reg}));
    assign cprod = CPROD_W'(c1_center_reg) * CPROD_W'($signed({1'b0, cfg_cweight_reg}));

    // Accumulate and take the magnitude
    logic signed [ACC_W-1:0] acc;
    logic signed [ACC_W-1:0] acc_abs;

    assign acc     = ACC_W'(c2_nprod_reg) + ACC_W'(c2_cprod_reg);
    assign acc_abs = acc[ACC_W-1] ? -acc : acc;

    // Quotient, sign restore and saturation
    logic [QUO_W-1:0]       quo;
    logic signed [QS_W-1:0] quo_s;
    logic signed [QS_W-1:0] quo_signed;

    assign quo        = c4_prod_reg[PROD_W-1:DIV_SHIFT];
    assign quo_s      = $signed({1'b0, quo});
    assign quo_signed = c4_neg_reg ? -quo_s : quo_s;

    always_ff @(posedge aclk) begin
        if (issue_fire) begin
            c1_nsum_reg   <= nsum;
            c1_center_reg <= n_ctr;
            c1_meta_reg   <= issue_meta;
        end
        if (c2_free && c1_valid_reg) begin
            c2_nprod_reg <= nprod;
            c2_cprod_reg <= cprod;
            c2_meta_reg  <= c1_meta_reg;
        end
        if (c3_free && c2_valid_reg) begin
            c3_mag_reg  <= acc_abs[MAG_W-1:0];
            c3_neg_reg  <= acc[ACC_W-1];
            c3_meta_reg <= c2_meta_reg;
        end
        if (c4_free && c3_valid_reg) begin
            c4_prod_reg <= PROD_W'(c3_mag_reg) * PROD_W'(DIV_MAGIC);
            c4_neg_reg  <= c3_neg_reg;
            c4_meta_reg <= c3_meta_reg;
        end
        if (c5_free && c4_valid_reg) begin
            if (quo_signed > QS_W'(SAMPLE_MAX)) begin
                m_item_reg.filtered <= SAMPLE_W'(SAMPLE_MAX);
            end else if (quo_signed < QS_W'(SAMPLE_MIN)) begin
                m_item_reg.filtered <= SAMPLE_W'(SAMPLE_MIN);
            end else begin
                m_item_reg.filtered <= quo_signed[SAMPLE_W-1:0];
            end
            m_item_reg.out_row      <= c4_meta_reg.row;
            m_item_reg.out_col      <= c4_meta_reg.col;
            m_item_reg.end_of_frame <= c4_meta_reg.eof;
            m_item_reg.last_of_run  <= c4_meta_reg.last;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

FILE: sv/wblur_checker.sv
// Checker on the top level's ports of the weighted 3x3 blur, with its bind.
`include "assert_macros.svh"

module wblur_checker (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_ready,
    input logic                 m_valid,
    input logic                 m_ready,
    input wblur_pkg::out_item_t m_item
);

    // A stalled result item holds
    `WB_ASSERT(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_item), "result item changed while stalled")

    // Reset empties the output and opens the input
    `WB_ASSERT_ALWAYS(a_rst_out_empty, aclk, !aresetn |=> !m_valid, "result valid after reset")
    `WB_ASSERT_ALWAYS(a_rst_in_ready, aclk, !aresetn |=> s_ready, "input not ready after reset")

    // The bottom right position is always the final result of its input item
    `WB_ASSERT(a_eof_last, aclk, aresetn, m_valid && m_item.end_of_frame |-> m_item.last_of_run, "end of frame without last of run")

    // A frame is at least two by two, so the last position is never on row or column 0
    `WB_ASSERT(a_eof_pos, aclk, aresetn, m_valid && m_item.end_of_frame |-> m_item.out_row != '0 && m_item.out_col != '0, "end of frame at row or column 0")

endmodule

bind weighted_3x3_blur_clamped wblur_checker u_wblur_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_item  (m_item)
);
